// ===== design/bblp_pkg.sv =====
// ----------------------------------------------------------------------------
// bblp_pkg
// Shared constants, codes and the command and status structures of the
// bouncing ball position block.
// ----------------------------------------------------------------------------
package bblp_pkg;

  localparam int MAX_BALLS = 16;
  localparam int BALL_W    = 4;
  localparam int MAX_LEDS  = 1024;

  localparam logic [15:0] DAMP_BASE   = 16'd58982;
  localparam logic [31:0] SPEED_MIN   = 32'd656;
  localparam logic [42:0] TIME_SCALE  = 43'd2000;

  // The height divisor of two million is split into a shift by seven and a
  // divide by 15625, done by a reciprocal that is exact below 2^30.
  localparam logic [13:0] HEIGHT_DIV    = 14'd15625;
  localparam logic [30:0] HEIGHT_RECIP  = 31'd1125899907;
  localparam logic [2:0]  HEIGHT_DIGITS = 3'd4;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_FRAME = 1'b1;

  typedef enum logic [2:0] {
    REG_GRAVITY        = 3'd0,
    REG_START_HEIGHT   = 3'd1,
    REG_START_VELOCITY = 3'd2,
    REG_STRIP_LENGTH   = 3'd3,
    REG_BALLS_IN_USE   = 3'd4
  } reg_index_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_DAMP_DIV,
    OP_DAMP_WR,
    OP_INNER,
    OP_SUM,
    OP_BOUNCE,
    OP_ZERO,
    OP_FULL,
    OP_MULLO,
    OP_MULHI,
    OP_HDIV,
    OP_SCALE,
    OP_PDIV,
    OP_POS,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic req_type;
    logic n_zero;
    logic last;
    logic div_busy;
    logic t_zero;
    logic inner_neg;
    logic inner_pos;
    logic ovf;
    logic h_ge_s;
    logic out_free;
  } sts_t;

endpackage

// ===== design/bblp_if.sv =====
// ----------------------------------------------------------------------------
// bblp_req_if / bblp_pos_if
// Valid/ready channels for request words and ball position words.
// ----------------------------------------------------------------------------
interface bblp_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] now_ms;

  modport source (output valid, req_type, now_ms, input ready);
  modport sink (input valid, req_type, now_ms, output ready);
endinterface

interface bblp_pos_if;
  logic       valid;
  logic       ready;
  logic [3:0] ball_index;
  logic [9:0] led_position;
  logic       last_ball;

  modport source (output valid, ball_index, led_position, last_ball, input ready);
  modport sink (input valid, ball_index, led_position, last_ball, output ready);
endinterface

// ===== design/bblp_div.sv =====
// ----------------------------------------------------------------------------
// bblp_div
// Restoring divider, one quotient bit per cycle, 64-bit operands.
// ----------------------------------------------------------------------------
module bblp_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [64:0] rem;
  logic [63:0] dvs;
  logic [6:0]  count;
  logic [64:0] trial;
  logic        fits;

  assign trial = {rem[63:0], quotient[63]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 7'd64;
    end else if (busy) begin
      count <= count - 7'd1;
      busy  <= count != 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= fits ? trial - {1'b0, dvs} : trial;
      quotient <= {quotient[62:0], fits};
    end
  end

endmodule

// ===== design/bblp_datapath.sv =====
// ----------------------------------------------------------------------------
// bblp_datapath
// Configuration registers, per-ball state, arithmetic steps and the output
// register, driven one step at a time by the controller.
// ----------------------------------------------------------------------------
module bblp_datapath import bblp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_req_type,
  input  logic [31:0] in_now_ms,
  input  cmd_t        cmd,
  output sts_t        sts,
  bblp_pos_if.source  pos
);

  logic [31:0] gravity;
  logic [30:0] start_height;
  logic [30:0] start_velocity;
  logic [10:0] strip_length;
  logic [4:0]  balls_in_use;

  logic        req_type;
  logic [31:0] now;
  logic [4:0]  n_act;
  logic [10:0] len_act;
  logic [30:0] s_act;
  logic [31:0] g_act;
  logic [BALL_W-1:0] ball;

  logic [31:0] bounce_time    [MAX_BALLS];
  logic [31:0] impact_speed   [MAX_BALLS];
  logic [15:0] damping_factor [MAX_BALLS];

  logic [31:0]        t;
  logic signed [65:0] gt;
  logic signed [65:0] inner;
  logic [75:0]        prod;
  logic [42:0]        num;
  logic [9:0]         position;

  logic [31:0]        t_c;
  logic signed [32:0] g33;
  logic signed [32:0] t33;
  logic signed [65:0] gt_c;
  logic [42:0]        sp2000;
  logic [47:0]        sp_full;
  logic [31:0]        sp;
  logic [53:0]        lo_c;
  logic [52:0]        hi_c;
  logic [9:0]         len_m1;
  logic [40:0]        sc_c;
  logic [9:0]         nsq;

  logic [63:0] hx;
  logic [13:0] hr;
  logic [15:0] hq_d;
  logic [63:0] h;
  logic [2:0]  hcnt;
  logic        hphase;
  logic        hd_busy;
  logic [29:0] hpart;
  logic [60:0] hmul;
  logic [29:0] hrem_c;

  logic        div_start;
  logic [63:0] div_dividend;
  logic [63:0] div_divisor;
  logic        div_busy;
  logic [63:0] quot;

  assign t_c     = now - bounce_time[ball];
  assign g33     = $signed({g_act[31], g_act});
  assign t33     = $signed({1'b0, t_c});
  assign gt_c    = g33 * t33;
  assign sp2000  = 43'(impact_speed[ball]) * TIME_SCALE;
  assign sp_full = 48'(damping_factor[ball]) * 48'(impact_speed[ball]);
  assign sp      = sp_full[47:16];
  assign lo_c    = t * inner[21:0];
  assign hi_c    = t * inner[42:22];
  assign len_m1  = 10'(len_act - 11'd1);
  assign sc_c    = h[30:0] * len_m1;
  assign nsq     = n_act * n_act;

  assign hpart  = {hr, hx[63:48]};
  assign hmul   = 61'(hpart) * 61'(HEIGHT_RECIP);
  assign hrem_c = hpart - 30'(hq_d) * 30'(HEIGHT_DIV);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = {44'd0, ball, 16'd0};
    div_divisor  = {54'd0, nsq};
    case (cmd.op)
      OP_DAMP_DIV: div_start = 1'b1;
      OP_PDIV: begin
        div_start    = 1'b1;
        div_dividend = {21'd0, num};
        div_divisor  = {32'd0, s_act, 1'b0};
      end
      default: ;
    endcase
  end

  bblp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (quot)
  );

  // The height is divided one 16-bit digit at a time in two phases: a reciprocal
  // multiply for the digit, then the remainder for the next one.
  always_ff @(posedge clk) begin
    if (rst) begin
      hd_busy <= 1'b0;
      hcnt    <= '0;
      hphase  <= 1'b0;
    end else if (cmd.op == OP_HDIV) begin
      hd_busy <= 1'b1;
      hcnt    <= HEIGHT_DIGITS;
      hphase  <= 1'b0;
    end else if (hd_busy) begin
      hphase <= !hphase;
      if (hphase) begin
        hcnt    <= hcnt - 3'd1;
        hd_busy <= hcnt != 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_HDIV) begin
      hx <= {7'd0, prod[63:7]};
      hr <= '0;
      h  <= '0;
    end else if (hd_busy) begin
      if (!hphase) begin
        hq_d <= hmul[59:44];
      end else begin
        hr <= hrem_c[13:0];
        hx <= {hx[47:0], 16'd0};
        h  <= {h[47:0], hq_d};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity        <= 32'hFFF6_3024;
      start_height   <= 31'd65536;
      start_velocity <= 31'd290288;
      strip_length   <= 11'd60;
      balls_in_use   <= 5'd3;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRAVITY:        gravity        <= cfg_data;
        REG_START_HEIGHT:   start_height   <= cfg_data[30:0];
        REG_START_VELOCITY: start_velocity <= cfg_data[30:0];
        REG_STRIP_LENGTH:   strip_length   <= cfg_data[10:0];
        REG_BALLS_IN_USE:   balls_in_use   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_BALLS; i++) begin
        bounce_time[i]    <= '0;
        impact_speed[i]   <= '0;
        damping_factor[i] <= '0;
      end
      ball <= '0;
    end else begin
      case (cmd.op)
        OP_LATCH: ball <= '0;
        OP_DAMP_WR: begin
          bounce_time[ball]    <= now;
          impact_speed[ball]   <= {1'b0, start_velocity};
          damping_factor[ball] <= DAMP_BASE - quot[15:0];
          ball                 <= ball + 1'b1;
        end
        OP_BOUNCE: begin
          bounce_time[ball]  <= now;
          impact_speed[ball] <= (sp < SPEED_MIN) ? {1'b0, start_velocity} : sp;
        end
        OP_EMIT: ball <= ball + 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LATCH: begin
        req_type <= in_req_type;
        now      <= in_now_ms;
        n_act    <= (balls_in_use > 5'(MAX_BALLS)) ? 5'(MAX_BALLS) : balls_in_use;
        len_act  <= (strip_length == 11'd0) ? 11'd1 :
                    (strip_length > 11'(MAX_LEDS)) ? 11'(MAX_LEDS) : strip_length;
        s_act    <= (start_height == 31'd0) ? 31'd1 : start_height;
        g_act    <= gravity[31] ? gravity : 32'd0;
      end
      OP_INNER: begin
        t  <= t_c;
        gt <= gt_c;
      end
      OP_SUM:    inner    <= gt + $signed({23'd0, sp2000});
      OP_BOUNCE: position <= '0;
      OP_ZERO:   position <= '0;
      OP_FULL:   position <= len_m1;
      OP_MULLO:  prod     <= {22'd0, lo_c};
      OP_MULHI:  prod     <= prod + {1'b0, hi_c, 22'd0};
      OP_SCALE:  num      <= {1'b0, sc_c, 1'b0} + {12'd0, s_act};
      OP_POS:    position <= quot[9:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos.valid <= 1'b0;
    end else if (cmd.op == OP_EMIT) begin
      pos.valid <= 1'b1;
    end else if (pos.ready) begin
      pos.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      pos.ball_index   <= ball;
      pos.led_position <= position;
      pos.last_ball    <= sts.last;
    end
  end

  always_comb begin
    sts.req_type  = req_type;
    sts.n_zero    = n_act == 5'd0;
    sts.last      = {1'b0, ball} == 5'(n_act - 5'd1);
    sts.div_busy  = div_busy || hd_busy;
    sts.t_zero    = t == 32'd0;
    sts.inner_neg = inner[65];
    sts.inner_pos = !inner[65] && (inner != 66'sd0);
    sts.ovf       = |prod[75:64];
    sts.h_ge_s    = h >= {33'd0, s_act};
    sts.out_free  = !pos.valid || pos.ready;
  end

endmodule

// ===== design/bblp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bblp_ctrl
// Sequencer that walks the balls of a start or frame word through the
// datapath steps.
// ----------------------------------------------------------------------------
module bblp_ctrl import bblp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [12:0] {
    ST_IDLE     = 13'b0000000000001,
    ST_DISPATCH = 13'b0000000000010,
    ST_S_LAUNCH = 13'b0000000000100,
    ST_S_WAIT   = 13'b0000000001000,
    ST_F_INNER  = 13'b0000000010000,
    ST_F_SUM    = 13'b0000000100000,
    ST_F_DECIDE = 13'b0000001000000,
    ST_F_MULHI  = 13'b0000010000000,
    ST_F_CHK    = 13'b0000100000000,
    ST_F_HWAIT  = 13'b0001000000000,
    ST_F_PDIV   = 13'b0010000000000,
    ST_F_PWAIT  = 13'b0100000000000,
    ST_F_EMIT   = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = state == ST_IDLE;

  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LATCH;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (sts.n_zero) begin
          state_next = ST_IDLE;
        end else if (sts.req_type == REQ_START) begin
          state_next = ST_S_LAUNCH;
        end else begin
          state_next = ST_F_INNER;
        end
      end
      ST_S_LAUNCH: begin
        cmd.op     = OP_DAMP_DIV;
        state_next = ST_S_WAIT;
      end
      ST_S_WAIT: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_DAMP_WR;
          state_next = sts.last ? ST_IDLE : ST_S_LAUNCH;
        end
      end
      ST_F_INNER: begin
        cmd.op     = OP_INNER;
        state_next = ST_F_SUM;
      end
      ST_F_SUM: begin
        cmd.op     = OP_SUM;
        state_next = ST_F_DECIDE;
      end
      ST_F_DECIDE: begin
        if (!sts.t_zero && sts.inner_neg) begin
          cmd.op     = OP_BOUNCE;
          state_next = ST_F_EMIT;
        end else if (sts.t_zero || !sts.inner_pos) begin
          cmd.op     = OP_ZERO;
          state_next = ST_F_EMIT;
        end else begin
          cmd.op     = OP_MULLO;
          state_next = ST_F_MULHI;
        end
      end
      ST_F_MULHI: begin
        cmd.op     = OP_MULHI;
        state_next = ST_F_CHK;
      end
      ST_F_CHK: begin
        if (sts.ovf) begin
          cmd.op     = OP_FULL;
          state_next = ST_F_EMIT;
        end else begin
          cmd.op     = OP_HDIV;
          state_next = ST_F_HWAIT;
        end
      end
      ST_F_HWAIT: begin
        if (!sts.div_busy) begin
          if (sts.h_ge_s) begin
            cmd.op     = OP_FULL;
            state_next = ST_F_EMIT;
          end else begin
            cmd.op     = OP_SCALE;
            state_next = ST_F_PDIV;
          end
        end
      end
      ST_F_PDIV: begin
        cmd.op     = OP_PDIV;
        state_next = ST_F_PWAIT;
      end
      ST_F_PWAIT: begin
        if (!sts.div_busy) begin
          cmd.op     = OP_POS;
          state_next = ST_F_EMIT;
        end
      end
      ST_F_EMIT: begin
        if (sts.out_free) begin
          cmd.op     = OP_EMIT;
          state_next = sts.last ? ST_IDLE : ST_F_INNER;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |-> sts.out_free)
    else $error("position word loaded over an untaken word");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_DAMP_DIV || cmd.op == OP_HDIV || cmd.op == OP_PDIV) |-> !sts.div_busy)
    else $error("divider restarted while busy");

  a_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == ST_DISPATCH)
    else $error("accepted word not dispatched");

endmodule

// ===== design/bouncing_ball_led_positions.sv =====
// ----------------------------------------------------------------------------
// bouncing_ball_led_positions
// Bouncing balls under gravity: start words launch the balls, frame words
// return one rounded LED position per active ball.
//
//   channel  role   payload
//   req      sink   req_type, now_ms
//   pos      source ball_index, led_position, last_ball
//   cfg      write  cfg_write, cfg_index, cfg_data
//
// Every word is first accepted in the idle state and then dispatched.
// A start word then runs a damping division on the serial divider for each ball.
// A frame word ends a ball early on a bounce, a zero or a full-strip result;
// else the height division and the 64-step division by the start height follow.
// Synchronous reset restores the default registers and clears all ball state.
// A stalled position word holds the sequencer at that ball.
// ----------------------------------------------------------------------------
module bouncing_ball_led_positions import bblp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  bblp_req_if.sink    req,
  bblp_pos_if.source  pos,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  bblp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bblp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_req_type (req.req_type),
    .in_now_ms   (req.now_ms),
    .cmd         (cmd),
    .sts         (sts),
    .pos         (pos)
  );

endmodule
